// ===== rtl/wps_pkg.sv =====
// Shared constants, types and fixed-point helpers for the waveguide plucked-string core.
package wps_pkg;

    localparam int C_MAX_RAIL   = 1024;
    localparam int C_SAMPLE_W   = 24;
    localparam int C_COEF_W     = 18;
    localparam int C_TUNE_W     = 17;
    localparam int C_POS_W      = 11;
    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 24;
    localparam int C_FRAC_BITS  = 16;

    localparam logic [C_POS_W-1:0]         C_RST_RAIL_LENGTH   = 11'd100;
    localparam logic [C_POS_W-1:0]         C_RST_PICK_POINT    = 11'd10;
    localparam logic signed [C_COEF_W-1:0] C_RST_BRIDGE_CENTER = 18'sd65536;

    typedef logic signed [63:0]           t_wide;
    typedef logic signed [C_SAMPLE_W-1:0] t_sample;

    localparam t_wide C_RND_HALF = 64'sd32768;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_PLUCK = 1'b1
    } t_opcode;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        REG_RAIL_LENGTH   = 3'd0,
        REG_PICK_POINT    = 3'd1,
        REG_PEAK_LEVEL    = 3'd2,
        REG_RISE_STEP     = 3'd3,
        REG_FALL_STEP     = 3'd4,
        REG_BRIDGE_OUTER  = 3'd5,
        REG_BRIDGE_CENTER = 3'd6,
        REG_TUNING_COEF   = 3'd7
    } t_reg_idx;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_PLUCK = 7'b0000100,
        ST_RD1   = 7'b0001000,
        ST_FIR   = 7'b0010000,
        ST_Q     = 7'b0100000,
        ST_WR    = 7'b1000000
    } t_state;

    // Q16 product back to sample scale, rounding half up (floor of x/2^16 + 1/2).
    function automatic t_wide f_rnd16(input t_wide v);
        return (v + C_RND_HALF) >>> C_FRAC_BITS;
    endfunction

    // Saturate to the signed sample range.
    function automatic t_sample f_sat(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (64'sd1 <<< (C_SAMPLE_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return t_sample'(hi);
        end else if (v < lo) begin
            return t_sample'(lo);
        end
        return t_sample'(v);
    endfunction

endpackage

// ===== rtl/waveguide_plucked_string_core.sv =====
// Waveguide plucked-string synthesizer core: two delay rails in memory plus bridge filter.
//
// Usage. Write configuration registers (i_cfg_we/i_cfg_index/i_cfg_data) only while
// idle, which the core does not check. Input beats arrive on i_in_valid/o_in_ready and
// carry an opcode: a pluck loads a triangle into both rails and gives no output beat,
// a tick produces one output sample. Output beats leave on o_out_valid/i_out_ready.
//
// Timing. A tick occupies the core from its accept edge to the next edge at which
// o_in_ready can be high again; its sample appears on o_out_valid right at that point.
// The length of a tick is set by the two single-port rail memories (three accesses
// each per tick) and the allpass recursion, whose second product depends on the first.
// A pluck writes one rail entry of each rail per cycle, over the effective rail length.
//
// Reset. After reset the core sweeps all MAX_RAIL entries (1024 by default) of both
// rails to zero, one entry per cycle; o_in_ready stays low during the sweep.
//
// Stall. A finished sample waits in the output register. The core keeps accepting a
// new beat while it waits; a following tick holds in its final step until the output
// register frees, so no sample is dropped or duplicated.
module waveguide_plucked_string_core
    import wps_pkg::*;
#(
    parameter int MAX_RAIL = C_MAX_RAIL
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [C_CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_opcode,
    input  logic signed [C_SAMPLE_W-1:0] i_feedback_sample,
    input  logic [C_POS_W-1:0]           i_pickup_tap,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [C_SAMPLE_W-1:0] o_sample_out
);

    localparam int AW    = $clog2(MAX_RAIL);
    localparam int LW    = $clog2(MAX_RAIL + 1);
    localparam int ACC_W = C_COEF_W + LW + 1;
    localparam int SW    = C_SAMPLE_W;

    // Control state.
    t_state r_state;
    t_state n_state;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] r_widx;
    logic          r_out_valid;

    // Configuration registers.
    logic [C_POS_W-1:0]         r_rail_length;
    logic [C_POS_W-1:0]         r_pick_point;
    logic signed [SW-1:0]       r_peak_level;
    logic signed [C_COEF_W-1:0] r_rise_step;
    logic signed [C_COEF_W-1:0] r_fall_step;
    logic signed [C_COEF_W-1:0] r_bridge_outer;
    logic signed [C_COEF_W-1:0] r_bridge_center;
    logic signed [C_TUNE_W-1:0] r_tuning_coef;

    // Filter state.
    logic signed [SW-1:0] r_h1;
    logic signed [SW-1:0] r_h2;
    logic signed [SW-1:0] r_ap;

    // Per-beat datapath registers.
    logic [AW-1:0]        r_w;
    logic [AW-1:0]        r_uaddr;
    logic [LW-1:0]        r_pick;
    logic signed [SW-1:0] r_fb;
    logic signed [SW-1:0] r_tap;
    logic signed [SW-1:0] r_yl0;
    logic signed [SW-1:0] r_fir;
    logic signed [SW-1:0] r_res;
    logic signed [SW-1:0] r_q;
    logic signed [SW-1:0] r_sample_out;
    logic signed [SW+C_COEF_W:0]   r_prod_o;
    logic signed [SW+C_COEF_W-1:0] r_prod_c;
    logic signed [SW+C_TUNE_W-1:0] r_prod_ap;
    logic signed [SW+C_TUNE_W-1:0] r_prod_q;
    logic signed [ACC_W-1:0]       r_acc;

    // Rail memories, single port each, registered read data.
    logic signed [SW-1:0] r_upper_rail [MAX_RAIL];
    logic signed [SW-1:0] r_lower_rail [MAX_RAIL];
    logic signed [SW-1:0] r_up_q;
    logic signed [SW-1:0] r_lo_q;

    logic                 up_we;
    logic [AW-1:0]        up_addr;
    logic signed [SW-1:0] up_wd;
    logic                 lo_we;
    logic [AW-1:0]        lo_addr;
    logic signed [SW-1:0] lo_wd;

    // Combinational datapath values.
    logic [LW-1:0]        eff_len;
    logic [AW-1:0]        w_eff;
    logic [LW-1:0]        p_in;
    logic [LW-1:0]        k_pt;
    logic [LW-1:0]        d_p;
    logic [AW-1:0]        a_p_in;
    logic [AW-1:0]        a_lp;
    logic [AW-1:0]        a_nut;
    logic signed [SW:0]   lo_sum;
    logic signed [SW-1:0] pluck_val;
    logic signed [SW-1:0] nut_val;
    logic signed [SW-1:0] fir_val;
    logic signed [SW-1:0] res_val;
    logic signed [SW-1:0] s_val;
    logic signed [SW-1:0] q_val;
    logic signed [SW-1:0] y_val;
    logic signed [SW-1:0] upper_in;
    logic                 in_fire;
    logic                 wr_go;
    logic                 rising;

    // Clamp a position to 1..l.
    function automatic logic [LW-1:0] f_clamp(input logic [C_POS_W-1:0] v,
                                              input logic [LW-1:0] l);
        logic [31:0] ve;
        logic [31:0] le;
        ve = 32'(v);
        le = 32'(l);
        if (ve < 32'd1) begin
            ve = 32'd1;
        end else if (ve > le) begin
            ve = le;
        end
        return LW'(ve);
    endfunction

    // Index d elements behind w on a circular rail of length l, with d < l.
    function automatic logic [AW-1:0] f_back(input logic [AW-1:0] w,
                                             input logic [LW-1:0] d,
                                             input logic [LW-1:0] l);
        logic [LW:0] s;
        if ((LW+1)'(w) >= (LW+1)'(d)) begin
            s = (LW+1)'(w) - (LW+1)'(d);
        end else begin
            s = (LW+1)'(w) + (LW+1)'(l) - (LW+1)'(d);
        end
        return AW'(s);
    endfunction

    always_comb begin
        logic [31:0] len32;
        len32 = 32'(r_rail_length);
        if (len32 > 32'(MAX_RAIL)) begin
            len32 = 32'(MAX_RAIL);
        end else if (len32 < 32'd2) begin
            len32 = 32'd2;
        end
        eff_len = LW'(len32);
    end

    // A write index left beyond a shortened rail restarts at zero.
    assign w_eff = (LW'(r_widx) < eff_len) ? r_widx : '0;
    assign p_in  = f_clamp(i_pickup_tap, eff_len);
    assign k_pt  = f_clamp(r_pick_point, eff_len);

    // A pickup distance equal to the rail length lands on the write index itself.
    assign d_p    = (p_in == eff_len) ? '0 : p_in;
    assign a_p_in = f_back(w_eff, d_p, eff_len);
    assign a_lp   = f_back(r_w, eff_len - r_pick, eff_len);
    assign a_nut  = f_back(r_w, eff_len - LW'(1), eff_len);

    assign in_fire = (r_state == ST_IDLE) && i_in_valid;
    assign wr_go   = (r_state == ST_WR) && (!r_out_valid || i_out_ready);
    assign rising  = LW'(r_cnt) < k_pt;

    // Triangle value for the current pluck index; the accumulator holds the slope product.
    assign pluck_val = rising ? f_sat(f_rnd16(t_wide'(r_acc)))
                              : f_sat(t_wide'(r_peak_level) - f_rnd16(t_wide'(r_acc)));

    assign lo_sum   = (SW+1)'(r_lo_q) + (SW+1)'(r_h2);
    assign nut_val  = f_sat(-t_wide'(r_up_q));
    assign res_val  = f_sat(t_wide'(r_tap) + t_wide'(r_lo_q));
    assign fir_val  = f_sat(f_rnd16(t_wide'(r_prod_o) + t_wide'(r_prod_c)));
    assign s_val    = f_sat(-t_wide'(r_fir));
    assign q_val    = f_sat(t_wide'(s_val) + f_rnd16(t_wide'(r_prod_ap)));
    assign y_val    = f_sat(t_wide'(r_ap) - f_rnd16(t_wide'(r_prod_q)));
    assign upper_in = f_sat(t_wide'(y_val) + t_wide'(r_fb));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_cnt == AW'(MAX_RAIL - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_opcode == OP_PLUCK) ? ST_PLUCK : ST_RD1;
                end
            end
            ST_PLUCK: begin
                if (LW'(r_cnt) == eff_len - LW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD1: n_state = ST_FIR;
            ST_FIR: n_state = ST_Q;
            ST_Q:   n_state = ST_WR;
            ST_WR: begin
                if (wr_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Memory port schedule. Upper: tap read at accept, nut read, write-back last.
    // Lower: write-index read at accept, tap read, nut write-back.
    always_comb begin
        up_we   = 1'b0;
        up_addr = r_w;
        up_wd   = upper_in;
        lo_we   = 1'b0;
        lo_addr = r_w;
        lo_wd   = nut_val;
        unique case (r_state)
            ST_CLEAR: begin
                up_we   = 1'b1;
                up_addr = r_cnt;
                up_wd   = '0;
                lo_we   = 1'b1;
                lo_addr = r_cnt;
                lo_wd   = '0;
            end
            ST_IDLE: begin
                up_addr = a_p_in;
                lo_addr = w_eff;
            end
            ST_PLUCK: begin
                up_we   = 1'b1;
                up_addr = r_uaddr;
                up_wd   = pluck_val;
                lo_we   = 1'b1;
                lo_addr = r_cnt;
                lo_wd   = pluck_val;
            end
            ST_RD1: begin
                up_addr = a_nut;
                lo_addr = a_lp;
            end
            ST_FIR: begin
                lo_we = 1'b1;
            end
            ST_Q: begin
                up_we = 1'b0;
            end
            ST_WR: begin
                up_we = wr_go;
            end
            default: begin
                up_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (up_we) begin
            r_upper_rail[up_addr] <= up_wd;
        end else begin
            r_up_q <= r_upper_rail[up_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lo_we) begin
            r_lower_rail[lo_addr] <= lo_wd;
        end else begin
            r_lo_q <= r_lower_rail[lo_addr];
        end
    end

    // Control, configuration and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_cnt           <= '0;
            r_widx          <= '0;
            r_out_valid     <= 1'b0;
            r_rail_length   <= C_RST_RAIL_LENGTH;
            r_pick_point    <= C_RST_PICK_POINT;
            r_peak_level    <= '0;
            r_rise_step     <= '0;
            r_fall_step     <= '0;
            r_bridge_outer  <= '0;
            r_bridge_center <= C_RST_BRIDGE_CENTER;
            r_tuning_coef   <= '0;
            r_h1            <= '0;
            r_h2            <= '0;
            r_ap            <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_RAIL_LENGTH:   r_rail_length   <= i_cfg_data[C_POS_W-1:0];
                    REG_PICK_POINT:    r_pick_point    <= i_cfg_data[C_POS_W-1:0];
                    REG_PEAK_LEVEL:    r_peak_level    <= i_cfg_data[SW-1:0];
                    REG_RISE_STEP:     r_rise_step     <= i_cfg_data[C_COEF_W-1:0];
                    REG_FALL_STEP:     r_fall_step     <= i_cfg_data[C_COEF_W-1:0];
                    REG_BRIDGE_OUTER:  r_bridge_outer  <= i_cfg_data[C_COEF_W-1:0];
                    REG_BRIDGE_CENTER: r_bridge_center <= i_cfg_data[C_COEF_W-1:0];
                    REG_TUNING_COEF:   r_tuning_coef   <= i_cfg_data[C_TUNE_W-1:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                ST_CLEAR: r_cnt <= r_cnt + AW'(1);
                ST_IDLE: begin
                    if (in_fire && (i_opcode == OP_PLUCK)) begin
                        r_cnt  <= '0;
                        r_widx <= '0;
                        r_h1   <= '0;
                        r_h2   <= '0;
                        r_ap   <= '0;
                    end
                end
                ST_PLUCK: r_cnt <= r_cnt + AW'(1);
                ST_FIR: begin
                    r_h2 <= r_h1;
                    r_h1 <= r_yl0;
                end
                ST_WR: begin
                    if (wr_go) begin
                        r_ap   <= r_q;
                        r_widx <= a_nut;
                    end
                end
                default: begin
                end
            endcase

            if (wr_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_w     <= w_eff;
                    r_pick  <= p_in;
                    r_fb    <= i_feedback_sample;
                    r_uaddr <= AW'(eff_len - LW'(1));
                    r_acc   <= '0;
                end
            end
            ST_PLUCK: begin
                r_uaddr <= r_uaddr - AW'(1);
                if (rising) begin
                    if (LW'(r_cnt) + LW'(1) == k_pt) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= r_acc + ACC_W'(r_rise_step);
                    end
                end else begin
                    r_acc <= r_acc + ACC_W'(r_fall_step);
                end
            end
            ST_RD1: begin
                r_tap     <= r_up_q;
                r_yl0     <= r_lo_q;
                r_prod_o  <= r_bridge_outer * lo_sum;
                r_prod_c  <= r_bridge_center * r_h1;
                r_prod_ap <= r_tuning_coef * r_ap;
            end
            ST_FIR: begin
                r_fir <= fir_val;
                r_res <= res_val;
            end
            ST_Q: begin
                r_q      <= q_val;
                r_prod_q <= r_tuning_coef * q_val;
            end
            ST_WR: begin
                if (wr_go) begin
                    r_sample_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

// ===== rtl/wps_checker.sv =====
// Port-level assertions for the waveguide plucked-string core, bound to the top level.
module wps_checker
    import wps_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         i_opcode,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [C_SAMPLE_W-1:0] o_sample_out
);

    // A stalled output beat holds its sample.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("output beat changed while stalled");

    // The rail clearing sweep follows reset, so no beat is taken right after it.
    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("input ready during the clearing sweep");

    // A tick keeps the core busy on the following cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == OP_TICK) |=> !o_in_ready)
        else $error("tick did not occupy the core");

    // A new output beat only appears as the core finishes a tick.
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("output beat appeared without work in flight");

    // A pluck never produces an output beat.
    a_pluck_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == OP_PLUCK) |=> !$rose(o_out_valid))
        else $error("pluck produced an output beat");

endmodule

bind waveguide_plucked_string_core wps_checker u_wps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_opcode     (i_opcode),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out)
);
